// ===== design/hts_pkg.sv =====
// Types, constants and jamo lookup functions shared by the two-set Hangul composer.
`timescale 1ns / 1ps

package hts_pkg;

    // Index value meaning "no jamo"
    localparam logic [4:0] NONE_IDX = 5'd31;

    // Valid index ranges
    localparam logic [4:0] INI_COUNT = 5'd19;
    localparam logic [4:0] MED_COUNT = 5'd21;
    localparam logic [4:0] FIN_COUNT = 5'd28;
    localparam logic [4:0] LETTER_COUNT = 5'd26;

    // Codepoint bases
    localparam logic [15:0] SYL_BASE = 16'hAC00;
    localparam logic [15:0] CONS_BASE = 16'h3131;
    localparam logic [15:0] VOWEL_BASE = 16'h314F;
    localparam logic [15:0] SYL_PER_INI = 16'd588;   // 21 medials * 28 finals
    localparam logic [15:0] SYL_PER_MED = 16'd28;

    // Operation selector
    localparam logic OP_KEY = 1'b0;
    localparam logic OP_BACKSPACE = 1'b1;

    typedef enum logic [2:0] {
        KIND_PREEDIT = 3'd0,
        KIND_COMMIT  = 3'd1,
        KIND_ERASE   = 3'd2,
        KIND_PASS    = 3'd3,
        KIND_NOTUSED = 3'd4
    } hts_kind_t;

    typedef struct packed {
        logic [4:0] ini;
        logic [4:0] med;
        logic [4:0] fin;
        logic       composing;
    } hts_state_t;

    localparam hts_state_t STATE_CLEARED = '{ini: NONE_IDX, med: NONE_IDX,
                                             fin: NONE_IDX, composing: 1'b0};

    typedef struct packed {
        hts_kind_t   kind;
        logic [15:0] codepoint;
        logic        last;
    } hts_result_t;

    // Key tables, letters a..z
    localparam logic [4:0] KEY_PLAIN [26] = '{5'd6, 5'd17, 5'd14, 5'd11, 5'd3, 5'd5, 5'd18,
        5'd8, 5'd2, 5'd4, 5'd0, 5'd20, 5'd18, 5'd13, 5'd1, 5'd5, 5'd7, 5'd0, 5'd2, 5'd9,
        5'd6, 5'd17, 5'd12, 5'd16, 5'd12, 5'd15};
    localparam logic [4:0] KEY_SHIFT [26] = '{5'd6, 5'd17, 5'd14, 5'd11, 5'd4, 5'd5, 5'd18,
        5'd8, 5'd2, 5'd4, 5'd0, 5'd20, 5'd18, 5'd13, 5'd3, 5'd7, 5'd8, 5'd1, 5'd2, 5'd10,
        5'd6, 5'd17, 5'd13, 5'd16, 5'd12, 5'd15};
    // bit n set when letter n is a vowel key
    localparam logic [25:0] KEY_VOWEL = 26'h110FF82;

    // Compatibility consonant offsets from 0x3131, by initial index
    localparam logic [4:0] INI_JAMO_OFF [19] = '{5'h00, 5'h01, 5'h03, 5'h06, 5'h07, 5'h08,
        5'h10, 5'h11, 5'h12, 5'h14, 5'h15, 5'h16, 5'h17, 5'h18, 5'h19, 5'h1a, 5'h1b,
        5'h1c, 5'h1d};
    // initial -> final, zero when the consonant cannot close a syllable
    localparam logic [4:0] FIN_OF_INI [19] = '{5'd1, 5'd2, 5'd4, 5'd7, 5'd0, 5'd8, 5'd16,
        5'd17, 5'd0, 5'd19, 5'd20, 5'd21, 5'd22, 5'd0, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27};
    // final -> initial
    localparam logic [4:0] INI_OF_FIN [28] = '{5'd31, 5'd0, 5'd1, 5'd31, 5'd2, 5'd31,
        5'd31, 5'd3, 5'd5, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd6, 5'd7,
        5'd31, 5'd9, 5'd10, 5'd11, 5'd12, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18};

    function automatic logic ini_ok(input logic [4:0] i);
        return i < INI_COUNT;
    endfunction

    function automatic logic med_ok(input logic [4:0] m);
        return m < MED_COUNT;
    endfunction

    function automatic logic fin_ok(input logic [4:0] f);
        return (f != 5'd0) && (f < FIN_COUNT);
    endfunction

    function automatic logic [4:0] fin_of_init(input logic [4:0] i);
        logic [4:0] r;
        r = 5'd0;
        if (i < INI_COUNT) r = FIN_OF_INI[i];
        return r;
    endfunction

    function automatic logic [4:0] init_of_fin(input logic [4:0] f);
        logic [4:0] r;
        r = NONE_IDX;
        if (f < FIN_COUNT) r = INI_OF_FIN[f];
        return r;
    endfunction

    function automatic logic [4:0] join_medial(input logic [4:0] a, input logic [4:0] b);
        logic [4:0] r;
        r = NONE_IDX;
        if (a == 5'd8 && b == 5'd0) r = 5'd9;
        else if (a == 5'd8 && b == 5'd1) r = 5'd10;
        else if (a == 5'd8 && b == 5'd20) r = 5'd11;
        else if (a == 5'd13 && b == 5'd4) r = 5'd14;
        else if (a == 5'd13 && b == 5'd5) r = 5'd15;
        else if (a == 5'd13 && b == 5'd20) r = 5'd16;
        else if (a == 5'd18 && b == 5'd20) r = 5'd19;
        return r;
    endfunction

    function automatic logic [4:0] split_medial(input logic [4:0] v);
        logic [4:0] r;
        case (v)
            5'd9, 5'd10, 5'd11:  r = 5'd8;
            5'd14, 5'd15, 5'd16: r = 5'd13;
            5'd19:               r = 5'd18;
            default:             r = NONE_IDX;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] join_final(input logic [4:0] a, input logic [4:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (a == 5'd1 && b == 5'd19) r = 5'd3;
        else if (a == 5'd4 && b == 5'd22) r = 5'd5;
        else if (a == 5'd4 && b == 5'd27) r = 5'd6;
        else if (a == 5'd8 && b == 5'd1) r = 5'd9;
        else if (a == 5'd8 && b == 5'd16) r = 5'd10;
        else if (a == 5'd8 && b == 5'd17) r = 5'd11;
        else if (a == 5'd8 && b == 5'd19) r = 5'd12;
        else if (a == 5'd8 && b == 5'd25) r = 5'd13;
        else if (a == 5'd8 && b == 5'd26) r = 5'd14;
        else if (a == 5'd8 && b == 5'd27) r = 5'd15;
        else if (a == 5'd17 && b == 5'd19) r = 5'd18;
        return r;
    endfunction

    // First half left behind by a compound final; none for a simple final
    function automatic logic [4:0] split_final_head(input logic [4:0] v);
        logic [4:0] r;
        case (v)
            5'd3:                                   r = 5'd1;
            5'd5, 5'd6:                             r = 5'd4;
            5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15: r = 5'd8;
            5'd18:                                  r = 5'd17;
            default:                                r = NONE_IDX;
        endcase
        return r;
    endfunction

    // Part that detaches from a final; the whole final when it is simple
    function automatic logic [4:0] split_final_tail(input logic [4:0] v);
        logic [4:0] r;
        case (v)
            5'd3, 5'd12, 5'd18: r = 5'd19;
            5'd5:               r = 5'd22;
            5'd6, 5'd15:        r = 5'd27;
            5'd9:               r = 5'd1;
            5'd10:              r = 5'd16;
            5'd11:              r = 5'd17;
            5'd13:              r = 5'd25;
            5'd14:              r = 5'd26;
            default:            r = v;
        endcase
        return r;
    endfunction

    // Codepoint shown for a jamo set, zero when nothing is held
    function automatic logic [15:0] codepoint_of(input hts_state_t s);
        logic [15:0] f_eff;
        logic [15:0] r;
        f_eff = fin_ok(s.fin) ? 16'(s.fin) : 16'd0;
        r = 16'd0;
        if (ini_ok(s.ini) && med_ok(s.med))
            r = SYL_BASE + 16'(s.ini) * SYL_PER_INI + 16'(s.med) * SYL_PER_MED + f_eff;
        else if (ini_ok(s.ini))
            r = CONS_BASE + 16'(INI_JAMO_OFF[s.ini]);
        else if (med_ok(s.med))
            r = VOWEL_BASE + 16'(s.med);
        return r;
    endfunction

endpackage

// ===== design/hts_core.sv =====
// Composition step: next jamo state and up to two result words for one input word.
`timescale 1ns / 1ps

module hts_core (
    input  hts_pkg::hts_state_t  state,
    input  logic                 operation,
    input  logic [4:0]           key_letter,
    input  logic                 shift,
    output hts_pkg::hts_state_t  state_next,
    output hts_pkg::hts_result_t res0,
    output hts_pkg::hts_result_t res1,
    output logic [1:0]           res_count
);
    import hts_pkg::*;

    hts_state_t  nxt;
    hts_state_t  commit_st;
    logic        do_commit;
    logic        do_show;
    logic        e0_valid;
    logic        e1_valid;
    hts_kind_t   e1_kind;
    logic [15:0] e1_cp;
    logic [15:0] commit_cp;
    logic [15:0] show_cp;
    logic [4:0]  v;
    logic [4:0]  joined;
    logic [4:0]  moved;
    logic        iok;
    logic        mok;
    logic        fok;

    // Decide the jamo update and which words come out
    always_comb
    begin
        iok = ini_ok(state.ini);
        mok = med_ok(state.med);
        fok = fin_ok(state.fin);
        nxt = state;
        commit_st = state;
        do_commit = 1'b0;
        do_show = 1'b0;
        e1_valid = 1'b0;
        e1_kind = KIND_PREEDIT;
        e1_cp = 16'd0;
        v = KEY_PLAIN[key_letter];
        joined = NONE_IDX;
        moved = NONE_IDX;

        if (operation == OP_BACKSPACE)
        begin
            if (!state.composing)
            begin
                e1_valid = 1'b1;
                e1_kind = KIND_NOTUSED;
            end
            else
            begin
                if (fok)
                    nxt.fin = split_final_head(state.fin);
                else if (mok)
                    nxt.med = split_medial(state.med);
                else
                    nxt = STATE_CLEARED;
                // nothing left to show: erase
                if (!ini_ok(nxt.ini) && !med_ok(nxt.med))
                begin
                    e1_valid = 1'b1;
                    e1_kind = KIND_ERASE;
                    nxt = STATE_CLEARED;
                end
                else
                    do_show = 1'b1;
            end
        end
        else if (key_letter >= LETTER_COUNT)
        begin
            // non-Hangul key: flush syllable, pass key on
            do_commit = 1'b1;
            nxt = STATE_CLEARED;
            e1_valid = 1'b1;
            e1_kind = KIND_PASS;
        end
        else
        begin
            if (shift)
                v = KEY_SHIFT[key_letter];
            do_show = 1'b1;
            if (KEY_VOWEL[key_letter])
            begin
                joined = join_medial(state.med, v);
                if (!mok)
                    nxt.med = v;
                else if (fok)
                begin
                    // final (or its second half) moves on to the new syllable
                    moved = split_final_tail(state.fin);
                    commit_st.fin = split_final_head(state.fin);
                    do_commit = 1'b1;
                    nxt = STATE_CLEARED;
                    nxt.ini = init_of_fin(moved);
                    nxt.med = v;
                end
                else if (joined != NONE_IDX)
                    nxt.med = joined;
                else
                begin
                    do_commit = 1'b1;
                    nxt = STATE_CLEARED;
                    nxt.med = v;
                end
            end
            else
            begin
                if (iok && mok && !fok)
                    joined = fin_of_init(v);
                else if (iok && mok)
                    joined = join_final(state.fin, fin_of_init(v));
                else
                    joined = 5'd0;

                if (!iok && !mok)
                    nxt.ini = v;
                else if (joined != 5'd0)
                    nxt.fin = joined;
                else
                begin
                    do_commit = 1'b1;
                    nxt = STATE_CLEARED;
                    nxt.ini = v;
                end
            end
        end

        // preedit update
        show_cp = codepoint_of(nxt);
        if (do_show && show_cp != 16'd0)
        begin
            e1_valid = 1'b1;
            e1_kind = KIND_PREEDIT;
            e1_cp = show_cp;
            nxt.composing = 1'b1;
        end

        commit_cp = codepoint_of(commit_st);
        e0_valid = do_commit && state.composing && (commit_cp != 16'd0);
    end

    // Pack words, commit first
    always_comb
    begin
        res1 = '{kind: e1_kind, codepoint: e1_cp, last: 1'b1};
        if (e0_valid)
            res0 = '{kind: KIND_COMMIT, codepoint: commit_cp, last: !e1_valid};
        else
            res0 = res1;
    end

    assign res_count = {1'b0, e0_valid} + {1'b0, e1_valid};
    assign state_next = nxt;

endmodule

// ===== design/hangul_two_set_composer.sv =====
// Two-set Hangul composer top level: jamo state, composition step and result buffer.
// Output: a result word is presented on the master side in the cycle after the input word
// is accepted; a second word of the same input follows once the first is taken.
// Throughput: one input word per cycle while m_tready is high and each yields one result;
// after one that yields two, the next waits while the two-entry buffer drains one word a cycle.
// Reset: rst_n low clears the jamo indices to none, drops composing and empties the buffer.
`timescale 1ns / 1ps

module hangul_two_set_composer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [4:0] key_letter, [5] shift, [7:6] zero
    input  logic [0:0]  s_tuser,    // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] codepoint
    output logic [2:0]  m_tuser,    // [2:0] kind
    output logic        m_tlast
);
    import hts_pkg::*;

    hts_state_t  state_reg;
    hts_state_t  state_next;
    hts_result_t res0;
    hts_result_t res1;
    logic [1:0]  res_count;
    hts_result_t buf_reg [2];
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    hts_core u_core (
        .state      (state_reg),
        .operation  (s_tuser[0]),
        .key_letter (s_tdata[4:0]),
        .shift      (s_tdata[5]),
        .state_next (state_next),
        .res0       (res0),
        .res1       (res1),
        .res_count  (res_count)
    );

    // Handshakes: take a word once the buffer is empty or emptying
    assign s_tready = (count_reg == 2'd0) || (count_reg == 2'd1 && m_tready);
    assign push = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign pop = m_tvalid && m_tready;

    assign m_tdata = buf_reg[0].codepoint;
    assign m_tuser = buf_reg[0].kind;
    assign m_tlast = buf_reg[0].last;

    // Jamo state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_CLEARED;
        else if (push)
            state_reg <= state_next;
    end

    // Result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else if (push)
            count_reg <= res_count;
        else if (pop)
            count_reg <= count_reg - 2'd1;
    end

    // Result buffer payload, head at entry 0
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[0] <= res0;
            buf_reg[1] <= res1;
        end
        else if (pop)
            buf_reg[0] <= buf_reg[1];
    end

`ifndef SYNTH
    // Buffer never holds more than two words
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    // A word is taken only when the buffer is empty or drains in the same edge
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg == 2'd0 || pop))
        else $error("input accepted over pending results");

    // With two pending words only the second closes the run
    a_last_order: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> (buf_reg[1].last && !buf_reg[0].last))
        else $error("last marker misplaced");

    // Not composing means no jamo is held
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.composing |->
            (state_reg.ini == NONE_IDX && state_reg.med == NONE_IDX
             && state_reg.fin == NONE_IDX))
        else $error("jamo held while not composing");
`endif

endmodule

// ===== tb/hangul_two_set_composer_checker.sv =====
// Checker for the two-set Hangul composer: tracks the jamo state, predicts result words, compares.
`timescale 1ns / 1ps

module hangul_two_set_composer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [4:0] key_letter, [5] shift, [7:6] zero
    input  logic [0:0]  s_tuser,    // [0] operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [15:0] codepoint
    input  logic [2:0]  m_tuser,    // [2:0] kind
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          results_awaited
);

    localparam logic [4:0] NO_JAMO = 5'd31;
    localparam int SYL_ORIGIN = 'hAC00;
    localparam int CONS_ORIGIN = 'h3131;
    localparam int VOWEL_ORIGIN = 'h314F;

    // Jamo index per key a..z, plain and shifted
    localparam logic [4:0] PLAIN_JAMO [26] = '{5'd6, 5'd17, 5'd14, 5'd11, 5'd3, 5'd5, 5'd18,
        5'd8, 5'd2, 5'd4, 5'd0, 5'd20, 5'd18, 5'd13, 5'd1, 5'd5, 5'd7, 5'd0, 5'd2, 5'd9,
        5'd6, 5'd17, 5'd12, 5'd16, 5'd12, 5'd15};
    localparam logic [4:0] SHIFT_JAMO [26] = '{5'd6, 5'd17, 5'd14, 5'd11, 5'd4, 5'd5, 5'd18,
        5'd8, 5'd2, 5'd4, 5'd0, 5'd20, 5'd18, 5'd13, 5'd3, 5'd7, 5'd8, 5'd1, 5'd2, 5'd10,
        5'd6, 5'd17, 5'd13, 5'd16, 5'd12, 5'd15};
    // keys b h i j k l m n o p u y are vowels
    localparam logic [25:0] VOWEL_MASK = 26'b01_0001_0000_1111_1111_1000_0010;
    localparam logic [4:0] CONS_OFFSET [19] = '{5'h00, 5'h01, 5'h03, 5'h06, 5'h07, 5'h08,
        5'h10, 5'h11, 5'h12, 5'h14, 5'h15, 5'h16, 5'h17, 5'h18, 5'h19, 5'h1a, 5'h1b,
        5'h1c, 5'h1d};
    localparam logic [4:0] INI_TO_FIN [19] = '{5'd1, 5'd2, 5'd4, 5'd7, 5'd0, 5'd8, 5'd16,
        5'd17, 5'd0, 5'd19, 5'd20, 5'd21, 5'd22, 5'd0, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27};
    localparam logic [4:0] FIN_TO_INI [28] = '{5'd31, 5'd0, 5'd1, 5'd31, 5'd2, 5'd31,
        5'd31, 5'd3, 5'd5, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd6, 5'd7,
        5'd31, 5'd9, 5'd10, 5'd11, 5'd12, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18};

    // Predicted syllable state
    logic [4:0] cur_ini = NO_JAMO;
    logic [4:0] cur_med = NO_JAMO;
    logic [4:0] cur_fin = NO_JAMO;
    logic       showing = 1'b0;

    hts_pkg::hts_result_t step_words[$];
    hts_pkg::hts_result_t pending_results[$];
    int fails = 0;
    int awaited = 0;

    assign mismatch_count = fails;
    assign results_awaited = awaited;

    function automatic logic ini_held();
        return cur_ini < 5'd19;
    endfunction

    function automatic logic med_held();
        return cur_med < 5'd21;
    endfunction

    function automatic logic fin_held();
        return (cur_fin != 5'd0) && (cur_fin < 5'd28);
    endfunction

    function automatic logic [15:0] preedit_code();
        int fin_part;
        fin_part = fin_held() ? int'(cur_fin) : 0;
        if (ini_held() && med_held())
            return 16'(SYL_ORIGIN + (int'(cur_ini) * 21 + int'(cur_med)) * 28 + fin_part);
        if (ini_held())
            return 16'(CONS_ORIGIN + int'(CONS_OFFSET[cur_ini]));
        if (med_held())
            return 16'(VOWEL_ORIGIN + int'(cur_med));
        return 16'd0;
    endfunction

    function automatic logic [4:0] vowel_pair(input logic [4:0] a, input logic [4:0] b);
        if (a == 5'd8 && b == 5'd0) return 5'd9;
        if (a == 5'd8 && b == 5'd1) return 5'd10;
        if (a == 5'd8 && b == 5'd20) return 5'd11;
        if (a == 5'd13 && b == 5'd4) return 5'd14;
        if (a == 5'd13 && b == 5'd5) return 5'd15;
        if (a == 5'd13 && b == 5'd20) return 5'd16;
        if (a == 5'd18 && b == 5'd20) return 5'd19;
        return NO_JAMO;
    endfunction

    function automatic logic [4:0] vowel_unpair(input logic [4:0] v);
        if (v >= 5'd9 && v <= 5'd11) return 5'd8;
        if (v >= 5'd14 && v <= 5'd16) return 5'd13;
        if (v == 5'd19) return 5'd18;
        return NO_JAMO;
    endfunction

    // zero when the two finals do not combine
    function automatic logic [4:0] final_pair(input logic [4:0] a, input logic [4:0] b);
        if (a == 5'd1 && b == 5'd19) return 5'd3;
        if (a == 5'd4 && b == 5'd22) return 5'd5;
        if (a == 5'd4 && b == 5'd27) return 5'd6;
        if (a == 5'd8 && b == 5'd1) return 5'd9;
        if (a == 5'd8 && b == 5'd16) return 5'd10;
        if (a == 5'd8 && b == 5'd17) return 5'd11;
        if (a == 5'd8 && b == 5'd19) return 5'd12;
        if (a == 5'd8 && b == 5'd25) return 5'd13;
        if (a == 5'd8 && b == 5'd26) return 5'd14;
        if (a == 5'd8 && b == 5'd27) return 5'd15;
        if (a == 5'd17 && b == 5'd19) return 5'd18;
        return 5'd0;
    endfunction

    // head is zero for a simple final, tail is the part that detaches
    task automatic split_final(input logic [4:0] v, output logic [4:0] head,
                               output logic [4:0] tail);
        head = 5'd0;
        tail = v;
        case (v)
            5'd3:  begin head = 5'd1;  tail = 5'd19; end
            5'd5:  begin head = 5'd4;  tail = 5'd22; end
            5'd6:  begin head = 5'd4;  tail = 5'd27; end
            5'd9:  begin head = 5'd8;  tail = 5'd1;  end
            5'd10: begin head = 5'd8;  tail = 5'd16; end
            5'd11: begin head = 5'd8;  tail = 5'd17; end
            5'd12: begin head = 5'd8;  tail = 5'd19; end
            5'd13: begin head = 5'd8;  tail = 5'd25; end
            5'd14: begin head = 5'd8;  tail = 5'd26; end
            5'd15: begin head = 5'd8;  tail = 5'd27; end
            5'd18: begin head = 5'd17; tail = 5'd19; end
            default: ;
        endcase
    endtask

    task automatic emit_word(input hts_pkg::hts_kind_t k, input logic [15:0] cp);
        hts_pkg::hts_result_t w;
        if (step_words.size() < 2)
        begin
            w.kind = k;
            w.codepoint = cp;
            w.last = 1'b0;
            step_words.push_back(w);
        end
    endtask

    task automatic clear_jamo();
        cur_ini = NO_JAMO;
        cur_med = NO_JAMO;
        cur_fin = NO_JAMO;
        showing = 1'b0;
    endtask

    task automatic commit_syllable();
        logic [15:0] cp;
        cp = preedit_code();
        if (showing && cp != 16'd0) emit_word(hts_pkg::KIND_COMMIT, cp);
        clear_jamo();
    endtask

    task automatic show_preedit();
        logic [15:0] cp;
        cp = preedit_code();
        if (cp != 16'd0)
        begin
            emit_word(hts_pkg::KIND_PREEDIT, cp);
            showing = 1'b1;
        end
    endtask

    task automatic press_key(input logic [4:0] letter, input logic shifted);
        logic [4:0] v;
        logic [4:0] head;
        logic [4:0] tail;
        logic [4:0] next_ini;
        logic [4:0] joined;
        logic [4:0] as_fin;
        if (letter >= 5'd26)
        begin
            commit_syllable();
            emit_word(hts_pkg::KIND_PASS, 16'd0);
            return;
        end
        v = shifted ? SHIFT_JAMO[letter] : PLAIN_JAMO[letter];
        as_fin = (v < 5'd19) ? INI_TO_FIN[v] : 5'd0;
        if (VOWEL_MASK[letter])
        begin
            if (!med_held())
                cur_med = v;
            else if (fin_held())
            begin
                // final (or its second half) starts the next syllable
                split_final(cur_fin, head, tail);
                next_ini = (tail < 5'd28) ? FIN_TO_INI[tail] : NO_JAMO;
                cur_fin = (head != 5'd0) ? head : NO_JAMO;
                commit_syllable();
                cur_ini = next_ini;
                cur_med = v;
            end
            else
            begin
                joined = vowel_pair(cur_med, v);
                if (joined != NO_JAMO)
                    cur_med = joined;
                else
                begin
                    commit_syllable();
                    cur_med = v;
                end
            end
        end
        else
        begin
            if (!ini_held() && !med_held())
                cur_ini = v;
            else if (!med_held() || !ini_held())
            begin
                commit_syllable();
                cur_ini = v;
            end
            else if (!fin_held())
            begin
                if (as_fin != 5'd0)
                    cur_fin = as_fin;
                else
                begin
                    commit_syllable();
                    cur_ini = v;
                end
            end
            else
            begin
                joined = final_pair(cur_fin, as_fin);
                if (joined != 5'd0)
                    cur_fin = joined;
                else
                begin
                    commit_syllable();
                    cur_ini = v;
                end
            end
        end
        show_preedit();
    endtask

    task automatic press_backspace();
        logic [4:0] head;
        logic [4:0] tail;
        if (!showing)
        begin
            emit_word(hts_pkg::KIND_NOTUSED, 16'd0);
            return;
        end
        if (fin_held())
        begin
            split_final(cur_fin, head, tail);
            cur_fin = (head != 5'd0) ? head : NO_JAMO;
        end
        else if (med_held())
            cur_med = vowel_unpair(cur_med);
        else
        begin
            emit_word(hts_pkg::KIND_ERASE, 16'd0);
            clear_jamo();
            return;
        end
        if (!ini_held() && !med_held())
        begin
            emit_word(hts_pkg::KIND_ERASE, 16'd0);
            clear_jamo();
        end
        else
            show_preedit();
    endtask

    // Compare result words first, then predict from the accepted input word
    always @(posedge clk or negedge rst_n)
    begin : watch
        hts_pkg::hts_result_t want;
        hts_pkg::hts_result_t tail_word;
        if (!rst_n)
        begin
            clear_jamo();
            pending_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result word with none expected: kind %0d codepoint %h last %b",
                             $time, m_tuser, m_tdata, m_tlast);
                    fails++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $display("%0t: kind expected %0d actual %0d", $time, want.kind, m_tuser);
                        fails++;
                    end
                    if (m_tdata !== want.codepoint)
                    begin
                        $display("%0t: codepoint expected %h actual %h",
                                 $time, want.codepoint, m_tdata);
                        fails++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                step_words.delete();
                if (s_tuser[0] == hts_pkg::OP_BACKSPACE)
                    press_backspace();
                else
                    press_key(s_tdata[4:0], s_tdata[5]);
                if (step_words.size() > 0)
                begin
                    tail_word = step_words.pop_back();
                    tail_word.last = 1'b1;
                    step_words.push_back(tail_word);
                end
                foreach (step_words[i]) pending_results.push_back(step_words[i]);
            end
        end
        awaited = pending_results.size();
    end

endmodule

// ===== tb/hangul_two_set_composer_test.sv =====
// Testbench top for the two-set Hangul composer: keystroke stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps

module hangul_two_set_composer_test;

    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD = 300;
    localparam int HOLD_AT = 150;
    localparam int TOTAL_ITEMS = 550;
    localparam int DRAIN_CYCLES = 8;

    // Key groups, by letter index
    localparam logic [4:0] CONS_KEYS [14] = '{5'd0, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd16,
        5'd17, 5'd18, 5'd19, 5'd21, 5'd22, 5'd23, 5'd25};
    localparam logic [4:0] VOW_KEYS [12] = '{5'd1, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12,
        5'd13, 5'd14, 5'd15, 5'd20, 5'd24};
    // Key pairs that form compound vowels and compound finals
    localparam logic [4:0] VPAIR_A [7] = '{5'd7, 5'd7, 5'd7, 5'd13, 5'd13, 5'd13, 5'd12};
    localparam logic [4:0] VPAIR_B [7] = '{5'd10, 5'd14, 5'd11, 5'd9, 5'd15, 5'd11, 5'd11};
    localparam logic [4:0] FPAIR_A [11] = '{5'd17, 5'd18, 5'd18, 5'd5, 5'd5, 5'd5, 5'd5,
        5'd5, 5'd5, 5'd5, 5'd16};
    localparam logic [4:0] FPAIR_B [11] = '{5'd19, 5'd22, 5'd6, 5'd17, 5'd0, 5'd16, 5'd19,
        5'd23, 5'd21, 5'd6, 5'd19};

    typedef struct packed {
        logic       op;
        logic [4:0] letter;
        logic       shifted;
    } keystroke_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;    // [4:0] key_letter, [5] shift, [7:6] zero
    logic [0:0]  s_tuser = 1'b0;    // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [15:0] codepoint
    logic [2:0]  m_tuser;           // [2:0] kind
    logic        m_tlast;

    int mismatch_count;
    int results_awaited;
    int idle_cycles = 0;
    logic hold_request = 1'b0;
    logic holding = 1'b0;
    keystroke_t keystrokes[$];

    hangul_two_set_composer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    hangul_two_set_composer_checker composer_check (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .mismatch_count(mismatch_count),
        .results_awaited(results_awaited)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic add_key(input logic [4:0] letter, input logic shifted);
        keystroke_t k;
        k.op = hts_pkg::OP_KEY;
        k.letter = letter;
        k.shifted = shifted;
        keystrokes.push_back(k);
    endtask

    // Letter and shift are don't-care on backspace, so fill them at random
    task automatic add_backspace();
        keystroke_t k;
        k.op = hts_pkg::OP_BACKSPACE;
        k.letter = 5'($urandom_range(0, 31));
        k.shifted = 1'($urandom_range(0, 1));
        keystrokes.push_back(k);
    endtask

    function automatic logic rand_shift();
        return $urandom_range(0, 3) == 0;
    endfunction

    // One syllable typed the usual way: consonant, vowel, up to two finals
    task automatic add_syllable();
        int pick;
        if ($urandom_range(0, 9) != 0) add_key(CONS_KEYS[$urandom_range(0, 13)], rand_shift());
        if ($urandom_range(0, 4) == 0)
        begin
            pick = $urandom_range(0, 6);
            add_key(VPAIR_A[pick], 1'b0);
            add_key(VPAIR_B[pick], 1'b0);
        end
        else
            add_key(VOW_KEYS[$urandom_range(0, 11)], rand_shift());
        pick = $urandom_range(0, 99);
        if (pick < 35)
            add_key(CONS_KEYS[$urandom_range(0, 13)], rand_shift());
        else if (pick < 65)
        begin
            pick = $urandom_range(0, 10);
            add_key(FPAIR_A[pick], 1'b0);
            add_key(FPAIR_B[pick], 1'b0);
        end
    endtask

    task automatic build_keystrokes();
        keystroke_t k;
        int pick;
        // directed: unconsumed backspace, lone pass-through, compounds, splits, moves
        add_backspace();
        add_key(5'd26, 1'b0);
        add_key(5'd0, 1'b0);
        add_key(5'd10, 1'b0);
        add_key(5'd17, 1'b0);
        add_key(5'd19, 1'b0);
        add_key(5'd10, 1'b0);
        add_backspace();
        add_backspace();
        add_backspace();
        add_key(5'd7, 1'b0);
        add_key(5'd10, 1'b0);
        add_key(5'd17, 1'b1);
        add_key(5'd13, 1'b0);
        add_key(5'd9, 1'b0);
        add_key(5'd5, 1'b0);
        add_key(5'd23, 1'b0);
        add_backspace();
        add_backspace();
        add_backspace();
        add_key(5'd25, 1'b1);
        add_key(5'd14, 1'b1);
        add_key(5'd24, 1'b0);
        add_key(5'd31, 1'b0);
        add_key(5'd4, 1'b1);
        add_key(5'd15, 1'b1);
        add_key(5'd22, 1'b0);
        add_key(5'd4, 1'b1);
        // random: mostly syllables, with erasing, non-letter keys and noise
        while (keystrokes.size() < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                add_syllable();
            else if (pick < 82)
                repeat ($urandom_range(1, 4)) add_backspace();
            else if (pick < 90)
                add_key(5'($urandom_range(26, 31)), 1'($urandom_range(0, 1)));
            else
            begin
                k = keystroke_t'($urandom_range(0, 127));
                keystrokes.push_back(k);
            end
        end
    endtask

    // Receiver: stretches of full speed, random and sparse ready, plus one long hold
    initial
    begin : receiver
        int mode;
        int stretch;
        logic hold_done;
        hold_done = 1'b0;
        forever
        begin
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                holding = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holding = 1'b0;
            end
            mode = $urandom_range(0, 2);
            stretch = $urandom_range(10, 60);
            repeat (stretch)
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Sender: bursts of words with gaps, then drain and verdict
    initial
    begin : sender
        int burst_left;
        int idx;
        build_keystrokes();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(1, 30);
        idx = 0;
        foreach (keystrokes[i])
        begin
            if (idx == HOLD_AT) hold_request = 1'b1;
            if (burst_left == 0 && !holding)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = $urandom_range(1, 30);
            end
            s_tvalid <= 1'b1;
            s_tdata <= {2'b00, keystrokes[i].shifted, keystrokes[i].letter};
            s_tuser <= keystrokes[i].op;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            if (burst_left > 0) burst_left--;
            idx++;
        end
        s_tvalid <= 1'b0;
        // let the checker log the last word's results before polling the count
        @(posedge clk);
        while (results_awaited != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/hts_pkg.sv
design/hts_core.sv
design/hangul_two_set_composer.sv
tb/hangul_two_set_composer_checker.sv
tb/hangul_two_set_composer_test.sv
